>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/dkar_pkg.sv
// shared types and constants of the three-key debouncer
`default_nettype none

package dkar_pkg;

    localparam int unsigned NUM_KEYS  = 3;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned STAGES_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // key positions in the word
    localparam int unsigned KEY_DEC   = 0;
    localparam int unsigned KEY_CLEAR = 1;
    localparam int unsigned KEY_INC   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = 2'd2;

    // reset values
    localparam logic [CNT_W-1:0] FIRST_DELAY_RST  = 16'd300;
    localparam logic [CNT_W-1:0] REPEAT_DELAY_RST = 16'd100;
    localparam logic             PRESSED_LEVEL_RST = 1'b0;
    localparam logic             RELEASED_RST      = ~PRESSED_LEVEL_RST;

    typedef struct packed {
        logic edge_fire;   // accepted level just went to pressed
        logic hold;        // agreed pressed and unchanged: counts the shared counter
        logic oldest_next; // oldest stage after this tick's shift
        logic oldest_prev; // oldest stage before this tick's shift
    } lane_status_t;

endpackage

`default_nettype wire

>>> sv/three_key_debounce_autorepeat.sv
// top level: three-key debouncer with shared long-press auto-repeat
//
//  channel   direction  word bits (low first)                   handshake
//  s_        in         tdata[0] dec_level, [1] clear_level,     s_tvalid / s_tready
//                       [2] inc_level, [7:3] zero
//  m_        out        tdata[0] dec_event, [1] clear_event,     m_tvalid / m_tready
//                       [2] inc_event, [7:3] zero
//  cfg_      in         cfg_index selects register, cfg_data     cfg_we
//
// one word per cycle while s_tready is high: the three key lanes and the counter merge
//   work combinationally on each accepted word, and its result is registered into the
//   output register, or into the skid entry while the output word waits on m_tready
// a two-entry output stage (output register plus skid) keeps s_tready registered;
//   s_tready drops only when both entries hold words that m_ has not taken
// reset is synchronous and active low; it restores register defaults (300, 100,
//   pressed level low), all stages released and the hold counter at 300
`default_nettype none

`include "assert_macros.svh"

module three_key_debounce_autorepeat (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input words
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // dec_level, clear_level, inc_level
    // result words
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // dec_event, clear_event, inc_event
    // register writes
    input  wire logic                               cfg_we,
    input  wire logic [dkar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dkar_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic [dkar_pkg::CNT_W-1:0] first_delay_reg;
    logic [dkar_pkg::CNT_W-1:0] repeat_delay_reg;
    logic                       pressed_level_reg;

    // lane status and merged events
    dkar_pkg::lane_status_t               st_dec;
    dkar_pkg::lane_status_t               st_clear;
    dkar_pkg::lane_status_t               st_inc;
    logic [dkar_pkg::NUM_KEYS-1:0]        events;

    // output register and skid entry
    logic                                 m_valid_reg;
    logic [dkar_pkg::NUM_KEYS-1:0]        m_data_reg;
    logic                                 skid_valid_reg;
    logic [dkar_pkg::NUM_KEYS-1:0]        skid_data_reg;

    logic                                 accept;
    logic                                 out_free;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    // register writes, unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_delay_reg   <= dkar_pkg::FIRST_DELAY_RST;
            repeat_delay_reg  <= dkar_pkg::REPEAT_DELAY_RST;
            pressed_level_reg <= dkar_pkg::PRESSED_LEVEL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                dkar_pkg::REG_FIRST_DELAY:   first_delay_reg   <= cfg_data;
                dkar_pkg::REG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_data;
                dkar_pkg::REG_PRESSED_LEVEL: pressed_level_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // one lane per key
    dkar_lane u_lane_dec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (accept),
        .raw_level     (s_tdata[dkar_pkg::KEY_DEC]),
        .pressed_level (pressed_level_reg),
        .status        (st_dec)
    );

    dkar_lane u_lane_clear (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (accept),
        .raw_level     (s_tdata[dkar_pkg::KEY_CLEAR]),
        .pressed_level (pressed_level_reg),
        .status        (st_clear)
    );

    dkar_lane u_lane_inc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (accept),
        .raw_level     (s_tdata[dkar_pkg::KEY_INC]),
        .pressed_level (pressed_level_reg),
        .status        (st_inc)
    );

    // shared counter, chained dec -> clear -> rearm -> inc
    dkar_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (accept),
        .first_delay   (first_delay_reg),
        .repeat_delay  (repeat_delay_reg),
        .pressed_level (pressed_level_reg),
        .lane_dec      (st_dec),
        .lane_clear    (st_clear),
        .lane_inc      (st_inc),
        .events        (events)
    );

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (accept) begin
                m_data_reg <= events;
            end
        end else if (accept) begin
            skid_data_reg <= events;
        end
    end

    // skid entry only fills behind a waiting output word
    `ASSERT_RST(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> m_valid_reg, "skid holds a word while output is empty")
    // after an accepted word, the output always holds a valid word in the next cycle
    `ASSERT_RST(a_accept_to_out, aclk, aresetn, (s_tvalid && s_tready) |=> m_tvalid, "accepted word did not reach the output")
    // a stall of the output with a full skid keeps the input closed
    `ASSERT_RST(a_full_blocks, aclk, aresetn, (skid_valid_reg && !m_tready) |=> !s_tready, "input opened while both entries are full")
    // pad bits of the result word stay zero
    `ASSERT_ALWAYS(a_pad_zero, aclk, m_tdata[7:3] == 5'd0, "result pad bits not zero")

endmodule

`default_nettype wire

>>> sv/dkar_lane.sv
// one key lane: three-stage shift and accepted level
`default_nettype none

module dkar_lane (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire logic                 raw_level,
    input  wire logic                 pressed_level,
    output dkar_pkg::lane_status_t    status
);

    logic [dkar_pkg::STAGES_W-1:0] stages_reg;
    logic [dkar_pkg::STAGES_W-1:0] stages_next;
    logic                          accepted_reg;
    logic                          accepted_next;
    logic                          agree;
    logic                          agreed;
    logic                          change;

    always_comb begin
        stages_next = {stages_reg[dkar_pkg::STAGES_W-2:0], raw_level};
        agree       = (stages_next == '0) || (stages_next == '1);
        agreed      = stages_next[dkar_pkg::STAGES_W-1];
        change      = agree && (accepted_reg != agreed);
        accepted_next = change ? agreed : accepted_reg;

        status.edge_fire   = change && (agreed == pressed_level);
        status.hold        = agree && !change && (agreed == pressed_level);
        status.oldest_next = stages_next[dkar_pkg::STAGES_W-1];
        status.oldest_prev = stages_reg[dkar_pkg::STAGES_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stages_reg   <= {dkar_pkg::STAGES_W{dkar_pkg::RELEASED_RST}};
            accepted_reg <= dkar_pkg::RELEASED_RST;
        end else if (advance) begin
            stages_reg   <= stages_next;
            accepted_reg <= accepted_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/dkar_merge.sv
// shared hold counter: merges the lanes in dec, clear, inc order
`default_nettype none

module dkar_merge (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic [dkar_pkg::CNT_W-1:0]     first_delay,
    input  wire logic [dkar_pkg::CNT_W-1:0]     repeat_delay,
    input  wire logic                           pressed_level,
    input  wire dkar_pkg::lane_status_t         lane_dec,
    input  wire dkar_pkg::lane_status_t         lane_clear,
    input  wire dkar_pkg::lane_status_t         lane_inc,
    output logic [dkar_pkg::NUM_KEYS-1:0]       events
);

    logic [dkar_pkg::CNT_W-1:0] hold_counter_reg;
    logic [dkar_pkg::CNT_W-1:0] hold_counter_next;
    logic [dkar_pkg::CNT_W-1:0] cnt_dec;
    logic [dkar_pkg::CNT_W-1:0] cnt_clear;
    logic [dkar_pkg::CNT_W-1:0] cnt_mid;
    logic [dkar_pkg::CNT_W-1:0] dec_m1;
    logic [dkar_pkg::CNT_W-1:0] clear_m1;
    logic [dkar_pkg::CNT_W-1:0] inc_m1;
    logic                       rep_dec;
    logic                       rep_clear;
    logic                       rep_inc;
    logic                       released;
    logic                       rearm;

    always_comb begin
        released = ~pressed_level;

        // dec key step
        dec_m1  = hold_counter_reg - 16'd1;
        rep_dec = lane_dec.hold && (dec_m1 == '0);
        cnt_dec = !lane_dec.hold ? hold_counter_reg : (rep_dec ? repeat_delay : dec_m1);

        // clear key step
        clear_m1  = cnt_dec - 16'd1;
        rep_clear = lane_clear.hold && (clear_m1 == '0);
        cnt_clear = !lane_clear.hold ? cnt_dec : (rep_clear ? repeat_delay : clear_m1);

        // rearm when all keys look released; inc still shows last tick's stage
        rearm   = (lane_dec.oldest_next == released) && (lane_clear.oldest_next == released)
                  && (lane_inc.oldest_prev == released);
        cnt_mid = rearm ? first_delay : cnt_clear;

        // inc key step
        inc_m1  = cnt_mid - 16'd1;
        rep_inc = lane_inc.hold && (inc_m1 == '0);
        hold_counter_next = !lane_inc.hold ? cnt_mid : (rep_inc ? repeat_delay : inc_m1);

        events[dkar_pkg::KEY_DEC]   = lane_dec.edge_fire | rep_dec;
        events[dkar_pkg::KEY_CLEAR] = lane_clear.edge_fire | rep_clear;
        events[dkar_pkg::KEY_INC]   = lane_inc.edge_fire | rep_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_counter_reg <= dkar_pkg::FIRST_DELAY_RST;
        end else if (advance) begin
            hold_counter_reg <= hold_counter_next;
        end
    end

endmodule

`default_nettype wire
